[rtl/contiguous_ring_reserve_manager_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the contiguous ring reserve manager
// Both macros sample on clk and are disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef CONTIGUOUS_RING_RESERVE_MANAGER_MACROS_SVH
`define CONTIGUOUS_RING_RESERVE_MANAGER_MACROS_SVH

// Condition that must hold at every sampled edge
`define CRRM_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Antecedent at one edge implies consequent at the next edge
`define CRRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/crrm_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crrm_pkg
// Widths, request and status codes shared by the ring reserve manager.
// ---------------------------------------------------------------------------
package crrm_pkg;

  // position / length width: holds 0 .. MAX_BYTES
  localparam int POS_W = 17;
  localparam int OFS_W = 16;
  localparam int ST_W  = 3;
  localparam int OP_W  = 2;

  // APB register map
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic [POS_W-1:0] MAX_BYTES = 17'd65536;
  localparam logic [POS_W-1:0] MIN_BYTES = 17'd1;

  // register indexes
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_RESERVE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PEEK    = 2'd2,
    OP_POP     = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK           = 3'd0,
    ST_WAIT         = 3'd1,
    ST_TOO_LARGE    = 3'd2,
    ST_POP_OVERRUN  = 3'd3,
    ST_RELEASE_OVER = 3'd4,
    ST_ZERO_POP     = 3'd5
  } status_t;

endpackage

[rtl/crrm_stream_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crrm stream interfaces
// Valid/ready channels for requests and for results.
// ---------------------------------------------------------------------------
interface crrm_req_if;
  logic                        valid;
  logic                        ready;
  logic [crrm_pkg::OP_W-1:0]   op;
  logic [crrm_pkg::POS_W-1:0]  length;

  modport source (output valid, output op, output length, input ready);
  modport sink   (input valid, input op, input length, output ready);
endinterface

interface crrm_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [crrm_pkg::ST_W-1:0]   status;
  logic [crrm_pkg::OFS_W-1:0]  offset;
  logic [crrm_pkg::POS_W-1:0]  count;

  modport source (output valid, output status, output offset, output count, input ready);
  modport sink   (input valid, input status, input offset, input count, output ready);
endinterface

[rtl/contiguous_ring_reserve_manager.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// contiguous_ring_reserve_manager
// Pointer manager of a byte ring that hands out contiguous regions.
// ---------------------------------------------------------------------------
//  channel | dir | word
//  --------+-----+--------------------------------------------
//  req     | in  | op, length
//  rsp     | out | status, offset, count
//  apb     | in  | capacity register at byte address 0
//
//  One request per cycle sustained while results are taken; each passes
//  the request register, then the result register. The pointer update is
//  one pass of compares and adds on the state registers.
//  Reset clears the pointers and sets capacity and end mark to MAX_BYTES.
//  A stalled result holds in the result register while one more request
//  waits in the request register; ready drops only when both are full.
// ---------------------------------------------------------------------------
`include "contiguous_ring_reserve_manager_macros.svh"

module contiguous_ring_reserve_manager (
  input  logic                          clk,
  input  logic                          rst,
  crrm_req_if.sink                      req,
  crrm_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crrm_pkg::APB_AW-1:0]   paddr,
  input  logic [crrm_pkg::APB_DW-1:0]   pwdata,
  output logic [crrm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import crrm_pkg::*;

  // ring state
  logic [POS_W-1:0] capacity;
  logic [POS_W-1:0] head_pos, head_pos_next;
  logic [POS_W-1:0] tail_pos, tail_pos_next;
  logic [POS_W-1:0] end_mark, end_mark_next;
  logic [POS_W-1:0] reserved_len, reserved_len_next;
  logic             reserved_valid, reserved_valid_next;

  // request register
  logic             s1_valid;
  op_t              s1_op;
  logic [POS_W-1:0] s1_len;

  // result register
  logic             out_valid;
  status_t          out_status, status_next;
  logic [OFS_W-1:0] out_offset, offset_next;
  logic [POS_W-1:0] out_count, count_next;

  logic             advance;
  logic             cfg_write;
  logic [POS_W-1:0] cap_wdata, cap_clamped;

  // working values
  logic             torn;
  logic [POS_W-1:0] headroom;
  logic             drop;
  logic [POS_W-1:0] ph, pe;
  logic [POS_W:0]   pop_sum;

  // handshake
  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  // APB: always ready, writes to index 0 only
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign cap_wdata = pwdata[POS_W-1:0];
  assign prdata    = (paddr[2] == REG_CAPACITY) ? {{(APB_DW-POS_W){1'b0}}, capacity} : '0;

  always_comb begin
    if (cap_wdata < MIN_BYTES) cap_clamped = MIN_BYTES;
    else if (cap_wdata > MAX_BYTES) cap_clamped = MAX_BYTES;
    else cap_clamped = cap_wdata;
  end

  // headroom for reserve, and the exhausted-segment drop shared by peek and pop
  assign torn     = tail_pos < head_pos;
  assign headroom = torn ? (head_pos - tail_pos)
                  : ((end_mark > tail_pos) ? (end_mark - tail_pos) : '0);
  assign drop     = (s1_op == OP_PEEK) ? ((head_pos != tail_pos) && (head_pos == end_mark))
                                       : (head_pos == end_mark);
  assign ph       = drop ? '0 : head_pos;
  assign pe       = drop ? capacity : end_mark;
  assign pop_sum  = {1'b0, ph} + {1'b0, s1_len};

  // request evaluation
  always_comb begin
    status_next         = ST_OK;
    offset_next         = '0;
    count_next          = '0;
    head_pos_next       = head_pos;
    tail_pos_next       = tail_pos;
    end_mark_next       = end_mark;
    reserved_len_next   = reserved_len;
    reserved_valid_next = reserved_valid;
    unique case (s1_op)
      OP_RESERVE: begin
        if (s1_len > capacity) begin
          status_next = ST_TOO_LARGE;
        end else if (s1_len < headroom) begin
          reserved_len_next   = s1_len;
          reserved_valid_next = 1'b1;
          offset_next         = tail_pos[OFS_W-1:0];
        end else if (torn || (head_pos == '0)) begin
          status_next = ST_WAIT;
        end else begin
          // early wrap, then retry once against the head
          end_mark_next = tail_pos;
          tail_pos_next = '0;
          if (s1_len < head_pos) begin
            reserved_len_next   = s1_len;
            reserved_valid_next = 1'b1;
          end else begin
            status_next = ST_WAIT;
          end
        end
      end
      OP_RELEASE: begin
        if (!reserved_valid || (s1_len > reserved_len)) begin
          status_next = ST_RELEASE_OVER;
        end else begin
          tail_pos_next       = tail_pos + s1_len;
          reserved_len_next   = '0;
          reserved_valid_next = 1'b0;
        end
      end
      OP_PEEK: begin
        head_pos_next = ph;
        end_mark_next = pe;
        if (ph != tail_pos) begin
          offset_next = ph[OFS_W-1:0];
          if (ph < tail_pos) count_next = tail_pos - ph;
          else if (pe > ph) count_next = pe - ph;
          else count_next = '0;
        end
      end
      OP_POP: begin
        if (s1_len == '0) begin
          status_next = ST_ZERO_POP;
        end else if (pop_sum < {1'b0, pe}) begin
          end_mark_next = pe;
          head_pos_next = pop_sum[POS_W-1:0];
        end else if (pop_sum == {1'b0, pe}) begin
          end_mark_next = capacity;
          head_pos_next = '0;
        end else begin
          status_next = ST_POP_OVERRUN;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // state registers; a capacity write reinitialises the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity       <= MAX_BYTES;
      head_pos       <= '0;
      tail_pos       <= '0;
      end_mark       <= MAX_BYTES;
      reserved_len   <= '0;
      reserved_valid <= 1'b0;
    end else if (cfg_write) begin
      capacity       <= cap_clamped;
      head_pos       <= '0;
      tail_pos       <= '0;
      end_mark       <= cap_clamped;
      reserved_len   <= '0;
      reserved_valid <= 1'b0;
    end else if (advance) begin
      head_pos       <= head_pos_next;
      tail_pos       <= tail_pos_next;
      end_mark       <= end_mark_next;
      reserved_len   <= reserved_len_next;
      reserved_valid <= reserved_valid_next;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_op  <= op_t'(req.op);
      s1_len <= req.length;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= status_next;
      out_offset <= offset_next;
      out_count  <= count_next;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.offset = out_offset;
  assign rsp.count  = out_count;

  // checks
  `CRRM_ASSERT_ALWAYS(a_cap_nonzero, capacity != '0)
  `CRRM_ASSERT_NEXT(a_accept_loads, req.valid && req.ready && !cfg_write, s1_valid)
  `CRRM_ASSERT_NEXT(a_advance_shows, advance && !cfg_write, rsp.valid)
  `CRRM_ASSERT_NEXT(a_release_clears,
      advance && !cfg_write && (s1_op == OP_RELEASE) && (status_next == ST_OK),
      !reserved_valid)
  `CRRM_ASSERT_NEXT(a_grant_holds,
      advance && !cfg_write && (s1_op == OP_RESERVE) && (status_next == ST_OK),
      reserved_valid && (reserved_len == $past(s1_len)))

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for contiguous_ring_reserve_manager. A short scripted
// sequence walks the reset state, the length extremes, every error code and
// the wrap cases; random producer/consumer traffic follows under several
// capacity settings. Each result word is checked against a scripted word or
// an in-bench model of the ring pointers, with random idling on both sides.
// ---------------------------------------------------------------------------
module testbench;
  import crrm_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 4;
  localparam int PHASE_ITEMS  = 105;
  localparam int IDLE_LIMIT   = 4000;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [APB_AW-1:0] CAPACITY_ADDR = APB_AW'(4 * int'(REG_CAPACITY));

  typedef struct packed {
    status_t          status;
    logic [OFS_W-1:0] offset;
    logic [POS_W-1:0] count;
  } ring_word_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] length;
    logic             fixed;   // word below is the expected result
    ring_word_t       word;
  } script_row_t;

  localparam ring_word_t NO_WORD = '{ST_OK, 16'd0, 17'd0};

  // scripted requests, starting from the reset state (capacity 65536)
  localparam int SCRIPT_LEN = 32;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{OP_PEEK,    17'd0,      1'b1, '{ST_OK,           16'd0, 17'd0}},     // empty ring
    '{OP_POP,     17'd0,      1'b1, '{ST_ZERO_POP,     16'd0, 17'd0}},
    '{OP_RESERVE, 17'h1FFFF,  1'b1, '{ST_TOO_LARGE,    16'd0, 17'd0}},
    '{OP_RELEASE, 17'd0,      1'b1, '{ST_RELEASE_OVER, 16'd0, 17'd0}},     // nothing held
    '{OP_POP,     17'd65537,  1'b1, '{ST_POP_OVERRUN,  16'd0, 17'd0}},
    '{OP_POP,     17'd65536,  1'b1, '{ST_OK,           16'd0, 17'd0}},     // lands on end
    '{OP_RESERVE, 17'd65536,  1'b1, '{ST_WAIT,         16'd0, 17'd0}},     // no wrap at head 0
    '{OP_RESERVE, 17'd65535,  1'b1, '{ST_OK,           16'd0, 17'd0}},
    '{OP_RELEASE, 17'd65536,  1'b1, '{ST_RELEASE_OVER, 16'd0, 17'd0}},
    '{OP_RELEASE, 17'd65535,  1'b1, '{ST_OK,           16'd0, 17'd0}},
    '{OP_PEEK,    17'h1FFFF,  1'b1, '{ST_OK,           16'd0, 17'd65535}},
    '{OP_POP,     17'd65000,  1'b0, NO_WORD},
    '{OP_RESERVE, 17'd100,    1'b0, NO_WORD},   // early wrap, granted at 0
    '{OP_RELEASE, 17'd50,     1'b0, NO_WORD},
    '{OP_RESERVE, 17'd65000,  1'b0, NO_WORD},   // torn, no room
    '{OP_PEEK,    17'd0,      1'b0, NO_WORD},
    '{OP_POP,     17'd535,    1'b0, NO_WORD},   // reaches end mark, restores it
    '{OP_PEEK,    17'd0,      1'b0, NO_WORD},
    '{OP_POP,     17'd10,     1'b0, NO_WORD},
    '{OP_RESERVE, 17'd65490,  1'b0, NO_WORD},   // wraps, retry fails, wrap kept
    '{OP_PEEK,    17'd0,      1'b0, NO_WORD},
    '{OP_POP,     17'd40,     1'b0, NO_WORD},
    '{OP_RESERVE, 17'd20,     1'b0, NO_WORD},
    '{OP_RELEASE, 17'd20,     1'b0, NO_WORD},
    '{OP_POP,     17'd20,     1'b0, NO_WORD},
    '{OP_RESERVE, 17'd65530,  1'b0, NO_WORD},   // head left sitting on end mark
    '{OP_PEEK,    17'd0,      1'b0, NO_WORD},   // drops the spent segment
    '{OP_RESERVE, 17'd5,      1'b0, NO_WORD},
    '{OP_RELEASE, 17'd5,      1'b0, NO_WORD},
    '{OP_POP,     17'd5,      1'b0, NO_WORD},
    '{OP_RESERVE, 17'd65533,  1'b0, NO_WORD},
    '{OP_POP,     17'd3,      1'b0, NO_WORD}    // pop through the dropped segment
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  crrm_req_if req_ch ();
  crrm_rsp_if rsp_ch ();

  contiguous_ring_reserve_manager uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ring model state
  int unsigned ring_cap, ring_head, ring_tail, ring_end, held_len;
  bit          held_valid;

  ring_word_t  pending_words [$];
  int          errors, sent, checked, cfg_writes, quiet;
  int          status_seen [6];
  bit          tx_steady, rx_steady, hold_rx;

  function automatic void ring_restart(int unsigned cap);
    ring_cap   = cap;
    ring_head  = 0;
    ring_tail  = 0;
    ring_end   = cap;
    held_len   = 0;
    held_valid = 1'b0;
  endfunction

  // contiguous free bytes from the tail
  function automatic int unsigned free_run();
    if (ring_tail < ring_head) return ring_head - ring_tail;
    if (ring_end > ring_tail) return ring_end - ring_tail;
    return 0;
  endfunction

  // apply one request to the model, return the word it should produce
  function automatic ring_word_t ring_apply(op_t op, int unsigned len);
    ring_word_t  w;
    int unsigned h, e;
    w = NO_WORD;
    case (op)
      OP_RESERVE: begin
        if (len > ring_cap) begin
          w.status = ST_TOO_LARGE;
        end else if (len < free_run()) begin
          held_len   = len;
          held_valid = 1'b1;
          w.offset   = OFS_W'(ring_tail);
        end else if (ring_tail < ring_head || ring_head == 0) begin
          w.status = ST_WAIT;
        end else begin
          // early wrap: end mark comes down to the tail, retry from 0
          ring_end  = ring_tail;
          ring_tail = 0;
          if (len < free_run()) begin
            held_len   = len;
            held_valid = 1'b1;
            w.offset   = OFS_W'(ring_tail);
          end else begin
            w.status = ST_WAIT;
          end
        end
      end
      OP_RELEASE: begin
        if (!held_valid || len > held_len) begin
          w.status = ST_RELEASE_OVER;
        end else begin
          ring_tail  = ring_tail + len;
          held_len   = 0;
          held_valid = 1'b0;
        end
      end
      OP_PEEK: begin
        if (ring_head != ring_tail && ring_head == ring_end) begin
          ring_end  = ring_cap;
          ring_head = 0;
        end
        if (ring_head != ring_tail) begin
          w.offset = OFS_W'(ring_head);
          if (ring_head < ring_tail) w.count = POS_W'(ring_tail - ring_head);
          else if (ring_end > ring_head) w.count = POS_W'(ring_end - ring_head);
        end
      end
      default: begin
        if (len == 0) begin
          w.status = ST_ZERO_POP;
        end else begin
          h = ring_head;
          e = ring_end;
          if (h == e) begin
            e = ring_cap;
            h = 0;
          end
          if (h + len < e) begin
            ring_end  = e;
            ring_head = h + len;
          end else if (h + len == e) begin
            ring_end  = ring_cap;
            ring_head = 0;
          end else begin
            w.status = ST_POP_OVERRUN;
          end
        end
      end
    endcase
    return w;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // capacity write over APB; the model follows at the write edge
  task automatic write_capacity(logic [APB_DW-1:0] data);
    int unsigned v;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    v = data & 32'h1FFFF;
    if (v < MIN_BYTES) v = MIN_BYTES;
    if (v > MAX_BYTES) v = MAX_BYTES;
    ring_restart(v);
    cfg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // offer one request word, hold it until taken, then maybe idle
  task automatic send_request(op_t op, logic [POS_W-1:0] len, bit fixed,
                              ring_word_t fixed_word);
    ring_word_t predicted;
    int         gap;
    @(negedge clk);
    req_ch.valid  <= 1'b1;
    req_ch.op     <= op;
    req_ch.length <= len;
    do @(posedge clk); while (!req_ch.ready);
    predicted = ring_apply(op, len);
    pending_words.push_back(fixed ? fixed_word : predicted);
    sent++;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // drop valid and let every outstanding word come back
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly a well-behaved producer and consumer, with some noise
  task automatic random_request();
    op_t         op;
    int unsigned len, avail, h, e, pick, r;
    pick = $urandom_range(0, 99);
    r    = $urandom_range(0, 9);
    if (pick < 8) begin
      op  = op_t'($urandom_range(0, 3));
      len = (r < 5) ? ($urandom & 32'h1FFFF) : $urandom_range(0, ring_cap + 1);
    end else if (held_valid && pick < 40) begin
      op = OP_RELEASE;
      if (r == 0) len = held_len + 1;
      else if (r < 3) len = $urandom_range(0, held_len);
      else len = held_len;
    end else if (pick < 58) begin
      op = OP_RESERVE;
      if (r < 6) len = $urandom_range(0, ring_cap / 4 + 1);
      else if (r < 9) len = $urandom_range(0, ring_cap);
      else len = ring_cap + $urandom_range(0, 2);
    end else if (pick < 76) begin
      op  = OP_PEEK;
      len = $urandom & 32'h1FFFF;
    end else begin
      op = OP_POP;
      // bytes the consumer could take now, after any drop of the spent segment
      h = ring_head;
      e = ring_end;
      if (h != ring_tail && h == e) begin
        h = 0;
        e = ring_cap;
      end
      if (h == ring_tail) avail = 0;
      else if (h < ring_tail) avail = ring_tail - h;
      else if (e > h) avail = e - h;
      else avail = 0;
      if (avail == 0) len = (r < 3) ? 1 : 0;
      else if (r == 0) len = avail + 1;
      else len = $urandom_range(1, avail);
    end
    send_request(op, POS_W'(len), 1'b0, NO_WORD);
  endtask

  // result side: ready with random holds, one long hold on request
  initial begin
    int stall;
    stall = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        hold_rx = 1'b0;
        stall   = LONG_HOLD;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!rx_steady) stall = pick_gap();
      end
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin : check_words
    ring_word_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word: status %0d offset %0d count %0d",
                 $time, rsp_ch.status, rsp_ch.offset, rsp_ch.count);
        errors++;
      end else begin
        want = pending_words.pop_front();
        checked++;
        status_seen[int'(want.status)]++;
        if ({rsp_ch.status, rsp_ch.offset, rsp_ch.count} !== want) begin
          $display("%0t: mismatch: expected status %0d offset %0d count %0d,",
                   $time, want.status, want.offset, want.count);
          $display("%0t:           actual   status %0d offset %0d count %0d",
                   $time, rsp_ch.status, rsp_ch.offset, rsp_ch.count);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable && pready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [APB_DW-1:0] cap_settings [7];
    req_ch.valid  = 1'b0;
    req_ch.op     = OP_RESERVE;
    req_ch.length = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    errors        = 0;
    sent          = 0;
    checked       = 0;
    cfg_writes    = 0;
    quiet         = 0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    hold_rx       = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
    // small rings first, one of them clamped up, then the clamped maximum, 4096 and one random size
    cap_settings = '{32'h0000_0010, 32'h0000_0001, 32'h0000_0000, 32'hFFFE_00C8,
                     32'hFFFF_FFFF, 32'h0000_1000, 32'h0};
    cap_settings[6] = $urandom_range(2, 600);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    ring_restart(MAX_BYTES);

    // scripted part at the reset capacity
    foreach (SCRIPT[i])
      send_request(SCRIPT[i].op, SCRIPT[i].length, SCRIPT[i].fixed, SCRIPT[i].word);
    settle();

    // random phases, one capacity each
    foreach (cap_settings[p]) begin
      write_capacity(cap_settings[p]);
      tx_steady = (p % 3 == 1);
      rx_steady = (p % 3 == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // result side holds off while requests keep coming: block fills up
        if (p == 1 && n == 20) hold_rx = 1'b1;
        // request side stops until everything is back
        if (p == 2 && n == PHASE_ITEMS / 2) settle();
        random_request();
      end
      settle();
    end

    $display("Sent %0d requests over %0d capacity writes, %0d result words checked",
             sent, cfg_writes, checked);
    $display("Status mix: ok %0d wait %0d too-large %0d overrun %0d rel-over %0d zero-pop %0d",
             status_seen[ST_OK], status_seen[ST_WAIT], status_seen[ST_TOO_LARGE],
             status_seen[ST_POP_OVERRUN], status_seen[ST_RELEASE_OVER],
             status_seen[ST_ZERO_POP]);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
